// ----- design/repetition_code_decoder_unit_defines.svh -----
// Assertion macros for the repetition code decoder.
// Used by repetition_code_decoder_unit.sv; depends on nothing.
`ifndef REPETITION_CODE_DECODER_UNIT_DEFINES_SVH
`define REPETITION_CODE_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define RCD_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define RCD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/rcd_pkg.sv -----
// Shared types and constants of the repetition code decoder.
// No dependencies.
package rcd_pkg;

  localparam int unsigned LLR_W     = 8;
  localparam int unsigned IDX_W     = 10;
  localparam int unsigned FLEN_W    = 11;
  localparam int unsigned REPS_W    = 7;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [FLEN_W-1:0] FLEN_RESET = 11'd1024;
  localparam logic [REPS_W-1:0] REPS_RESET = 7'd3;
  localparam logic              SOFT_RESET = 1'b0;

  localparam logic signed [LLR_W-1:0] SUM_MAX  = 8'sd127;
  localparam logic signed [LLR_W-1:0] SUM_MIN  = -8'sd128;
  localparam logic signed [LLR_W-1:0] VOTE_POS = 8'sd1;
  localparam logic signed [LLR_W-1:0] VOTE_NEG = -8'sd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_LENGTH = 2'd0,
    CFG_REPETITIONS  = 2'd1,
    CFG_SOFT_MODE    = 2'd2
  } rcd_cfg_idx_e;

  // Classified request handed from front to back.
  typedef struct packed {
    logic signed [LLR_W-1:0] add;      // vote or LLR to accumulate
    logic                    saturate; // saturate instead of wrap
    logic                    first;    // overwrite accumulator
    logic                    last;     // emit a decision
    logic                    done;     // last position of the frame
  } rcd_op_t;

  typedef struct packed {
    logic             decoded_bit;
    logic [IDX_W-1:0] bit_index;
    logic             frame_done;
  } rcd_res_t;

endpackage

// ----- design/repetition_code_decoder_unit.sv -----
// Repetition code decoder, top level: front end, request queue, back end
// and result queue. Depends on rcd_pkg, rcd_fifo, rcd_front, rcd_back.
//
// Usage
// - Input queue: drive llr_i and raise push; the request is taken at a
//   rising edge with push high and full low. LLRs arrive repetition-major.
// - Result queue: while empty is low the oldest result sits on
//   decoded_bit_o, bit_index_o and frame_done_o; pop takes it.
// - Config: cfg_we_i writes cfg_data_i into register cfg_idx_i at the edge
//   (0 frame_length, 1 repetitions, 2 soft_mode); index 3 is ignored.
//   Write only while no request is in flight.
// - Throughput: one LLR per cycle unless a held pop stalls the back end,
//   set by the single read-modify-write of a position sum (one RAM read
//   and one write per cycle).
// - Path: request queue, then sum update, then result queue; requests of early repetitions give none.
// - Stall: a held pop fills the result queue, the back end then holds,
//   the request queue fills and full rises; nothing is dropped.
// - Reset: counters restart at position 0 of repetition 0, registers
//   return to 1024, 3, hard mode; the sum RAM is not cleared, the first
//   repetition overwrites it.
`include "repetition_code_decoder_unit_defines.svh"

module repetition_code_decoder_unit #(
  parameter int unsigned MAX_FRAME   = 1024,
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              push,
  output logic                              full,
  input  logic signed [rcd_pkg::LLR_W-1:0]  llr_i,
  output logic                              empty,
  input  logic                              pop,
  output logic                              decoded_bit_o,
  output logic [rcd_pkg::IDX_W-1:0]         bit_index_o,
  output logic                              frame_done_o,
  input  logic                              cfg_we_i,
  input  logic [rcd_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [rcd_pkg::CFG_W-1:0]         cfg_data_i
);
  import rcd_pkg::*;

  localparam int unsigned PW  = $clog2(MAX_FRAME);
  localparam int unsigned QW  = PW + $bits(rcd_op_t);
  localparam int unsigned RW  = $bits(rcd_res_t);

  logic          accept;
  logic [PW-1:0] f_pos, q_pos;
  rcd_op_t       f_op, q_op;
  logic          q_empty, q_pop;
  logic          res_push, res_full;
  rcd_res_t      res_in, res_out;

  // A request enters the front end only when the request queue has room.
  assign accept = push && !full;

  rcd_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .accept_i   (accept),
    .llr_i      (llr_i),
    .pos_o      (f_pos),
    .op_o       (f_op)
  );

  // Request queue decouples classification from the sum update.
  rcd_fifo #(
    .WIDTH (QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_req_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({f_pos, f_op}),
    .full_o  (full),
    .pop_i   (q_pop),
    .rdata_o ({q_pos, q_op}),
    .empty_o (q_empty)
  );

  rcd_back #(
    .MAX_FRAME (MAX_FRAME)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_empty_i  (q_empty),
    .q_pos_i    (q_pos),
    .q_op_i     (q_op),
    .q_pop_o    (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_o      (res_in)
  );

  // Result queue: the output register stage seen by the consumer.
  rcd_fifo #(
    .WIDTH (RW),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .wdata_i (res_in),
    .full_o  (res_full),
    .pop_i   (pop),
    .rdata_o (res_out),
    .empty_o (empty)
  );

  assign decoded_bit_o = res_out.decoded_bit;
  assign bit_index_o   = res_out.bit_index;
  assign frame_done_o  = res_out.frame_done;

  // Back end never pushes a result into a full result queue.
  `RCD_ASSERT_IMPL(a_res_no_overflow, res_push, !res_full, "result pushed into full queue")
  // Back end only pulls a request that is there.
  `RCD_ASSERT_IMPL(a_req_no_underflow, q_pop, !q_empty, "request popped from empty queue")
  // A result pushed while nothing is popped leaves the result queue non-empty.
  `RCD_ASSERT_NEXT(a_res_visible, res_push && !pop, !empty, "pushed result not visible")

endmodule

// ----- design/rcd_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module rcd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/rcd_fifo.sv -----
// Small register-based FIFO, used as the front/back queue and result queue.
// No dependencies.
module rcd_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW   = $clog2(DEPTH + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] wdata_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] rdata_o,
  output logic             empty_o
);

  logic [WIDTH-1:0] data_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]    count_q, count_d;
  logic             do_push, do_pop;

  assign full_o  = (count_q == CW'(DEPTH));
  assign empty_o = (count_q == '0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign rdata_o = data_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + AW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + AW'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CW'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      data_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// ----- design/rcd_front.sv -----
// Front end: configuration registers, position/repetition counters and
// classification of each accepted LLR. Depends on rcd_pkg.
module rcd_front #(
  parameter int unsigned MAX_FRAME = 1024,
  localparam int unsigned PW = $clog2(MAX_FRAME)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [rcd_pkg::CFG_IDX_W-1:0]        cfg_idx_i,
  input  logic [rcd_pkg::CFG_W-1:0]            cfg_data_i,
  input  logic                                 accept_i,
  input  logic signed [rcd_pkg::LLR_W-1:0]     llr_i,
  output logic [PW-1:0]                        pos_o,
  output rcd_pkg::rcd_op_t                     op_o
);
  import rcd_pkg::*;

  localparam int unsigned LENW = (PW + 1 > FLEN_W) ? PW + 1 : FLEN_W;

  logic [FLEN_W-1:0] flen_q;
  logic [REPS_W-1:0] reps_q;
  logic              soft_q;
  logic [PW-1:0]     pos_q, pos_d;
  logic [REPS_W-1:0] rep_q, rep_d;

  logic [LENW-1:0]   len_ext, len_eff, pos_nxt;
  logic [PW-1:0]     pos_eff;
  logic [REPS_W-1:0] reps_eff, rep_eff;
  logic [REPS_W:0]   rep_nxt;
  logic              pos_wrap;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      flen_q <= FLEN_RESET;
      reps_q <= REPS_RESET;
      soft_q <= SOFT_RESET;
    end else if (cfg_we_i) begin
      unique case (rcd_cfg_idx_e'(cfg_idx_i))
        CFG_FRAME_LENGTH: flen_q <= cfg_data_i[FLEN_W-1:0];
        CFG_REPETITIONS:  reps_q <= cfg_data_i[REPS_W-1:0];
        CFG_SOFT_MODE:    soft_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    len_ext = LENW'(flen_q);
    if (len_ext == '0) begin
      len_eff = LENW'(1);
    end else if (len_ext > LENW'(MAX_FRAME)) begin
      len_eff = LENW'(MAX_FRAME);
    end else begin
      len_eff = len_ext;
    end
    // Counters left out of range by a register write restart at zero.
    pos_eff  = (LENW'(pos_q) >= len_eff) ? '0 : pos_q;
    reps_eff = (reps_q == '0) ? REPS_W'(1) : reps_q;
    rep_eff  = (rep_q >= reps_eff) ? '0 : rep_q;

    pos_nxt  = LENW'(pos_eff) + LENW'(1);
    pos_wrap = (pos_nxt >= len_eff);
    rep_nxt  = {1'b0, rep_eff} + (REPS_W + 1)'(1);

    op_o.add      = soft_q ? llr_i : (llr_i[LLR_W-1] ? VOTE_NEG : VOTE_POS);
    op_o.saturate = soft_q;
    op_o.first    = (rep_eff == '0);
    op_o.last     = (rep_nxt == {1'b0, reps_eff});
    op_o.done     = pos_wrap;
    pos_o         = pos_eff;

    pos_d = pos_q;
    rep_d = rep_q;
    if (accept_i) begin
      if (pos_wrap) begin
        pos_d = '0;
        rep_d = op_o.last ? '0 : rep_nxt[REPS_W-1:0];
      end else begin
        pos_d = pos_nxt[PW-1:0];
        rep_d = rep_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      rep_q <= '0;
    end else begin
      pos_q <= pos_d;
      rep_q <= rep_d;
    end
  end

endmodule

// ----- design/rcd_back.sv -----
// Back end: read-modify-write of the per-position sums and the decision.
// Depends on rcd_pkg and rcd_ram.
module rcd_back #(
  parameter int unsigned MAX_FRAME = 1024,
  localparam int unsigned PW = $clog2(MAX_FRAME)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_empty_i,
  input  logic [PW-1:0]     q_pos_i,
  input  rcd_pkg::rcd_op_t  q_op_i,
  output logic              q_pop_o,
  input  logic              res_full_i,
  output logic              res_push_o,
  output rcd_pkg::rcd_res_t res_o
);
  import rcd_pkg::*;

  logic                    b_valid_q;
  logic [PW-1:0]           b_pos_q;
  rcd_op_t                 b_op_q;
  logic                    fwd_q;
  logic signed [LLR_W-1:0] fwd_data_q;

  logic [LLR_W-1:0]        ram_rdata;
  logic signed [LLR_W-1:0] old_sum, acc, sat_sum;
  logic signed [LLR_W:0]   sum9;
  logic                    fire, load;

  rcd_ram #(
    .WIDTH (LLR_W),
    .DEPTH (MAX_FRAME)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (fire),
    .waddr_i (b_pos_q),
    .wdata_i (acc),
    .re_i    (load),
    .raddr_i (q_pos_i),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    // A write at the edge of our read is not seen by the RAM: forward it.
    old_sum = fwd_q ? fwd_data_q : $signed(ram_rdata);
    sum9    = {old_sum[LLR_W-1], old_sum} + {b_op_q.add[LLR_W-1], b_op_q.add};
    if (sum9[LLR_W:LLR_W-1] == 2'b01) begin
      sat_sum = SUM_MAX;
    end else if (sum9[LLR_W:LLR_W-1] == 2'b10) begin
      sat_sum = SUM_MIN;
    end else begin
      sat_sum = sum9[LLR_W-1:0];
    end
    if (b_op_q.first) begin
      acc = b_op_q.add;
    end else if (b_op_q.saturate) begin
      acc = sat_sum;
    end else begin
      acc = sum9[LLR_W-1:0];
    end

    fire       = b_valid_q && (!b_op_q.last || !res_full_i);
    load       = !q_empty_i && (!b_valid_q || fire);
    q_pop_o    = load;
    res_push_o = fire && b_op_q.last;

    res_o.decoded_bit = acc[LLR_W-1];
    res_o.bit_index   = IDX_W'(b_pos_q);
    res_o.frame_done  = b_op_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (load) begin
      b_valid_q <= 1'b1;
    end else if (fire) begin
      b_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      b_pos_q    <= q_pos_i;
      b_op_q     <= q_op_i;
      fwd_q      <= fire && (b_pos_q == q_pos_i);
      fwd_data_q <= acc;
    end
  end

endmodule
